FILE: hw/rtl/dfw_pkg.sv
package dfw_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int RESULT_LIMIT     = 16;

  localparam int OP_W  = 2;
  localparam int VTX_W = 4;
  localparam int CNT_W = 5;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_WALK  = 2'd2;

endpackage

FILE: hw/rtl/graph_depth_first_walk_core.sv
// Depth-first walk engine over an undirected adjacency bit matrix.
// Input channel (in_valid/in_ready) carries one command per transfer:
//   clear graph, add undirected edge, or walk from in_from_vertex.
// Config channel (cfg_valid/cfg_ready) sets the vertex count; always ready.
// Output channel (out_valid/out_ready) gives one transfer per visited vertex,
//   in preorder, with out_last set on the final vertex of the walk.
// Steps: a clear is done in the idle state; an edge add is a read-modify-write
//   of both rows (one row for a self loop) through the single adjacency RAM.
//   A walk does one adjacency RAM read (S_W_RD) per search step (S_W_SRCH) in the
//   shared priority-search unit, which takes the lowest unvisited neighbour; it
//   pops a stack frame (S_W_POP) at each dead end and ends in S_W_END.
// The block takes one command at a time; in_ready is low until it finishes.
// A result is held back one step so its last flag is known; it moves into
//   the output register only when that register is free, so a stalled
//   receiver holds the walk at its next found vertex without loss.
// Reset clears the graph (row valid bits), the vertex count and all control
//   state at once; there is no clearing pass.
module graph_depth_first_walk_core #(
  parameter int MAX_VERTICES = dfw_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dfw_pkg::CNT_W-1:0]   cfg_vertex_count,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dfw_pkg::OP_W-1:0]    in_op,
  input  logic [dfw_pkg::VTX_W-1:0]   in_from_vertex,
  input  logic [dfw_pkg::VTX_W-1:0]   in_to_vertex,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dfw_pkg::VTX_W-1:0]   out_visited_vertex,
  output logic                        out_last
);
  import dfw_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int IW = VW + 1;
  localparam int DW = $clog2(MAX_VERTICES + 1);
  localparam int NW = $clog2(RESULT_LIMIT + 1);
  localparam int SW = VW + IW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_E_WA   = 3'd1;
  localparam logic [2:0] S_E_WB   = 3'd2;
  localparam logic [2:0] S_W_RD   = 3'd3;
  localparam logic [2:0] S_W_SRCH = 3'd4;
  localparam logic [2:0] S_W_POP  = 3'd5;
  localparam logic [2:0] S_W_END  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        vcount_r;
  logic [MAX_VERTICES-1:0] row_vld_r, row_vld_nxt;
  logic [VW-1:0]           e_a_r, e_a_nxt, e_b_r, e_b_nxt;
  logic [VW-1:0]           cur_v_r, cur_v_nxt;
  logic [IW-1:0]           cur_i_r, cur_i_nxt;
  logic [DW-1:0]           depth_r, depth_nxt;
  logic [NW-1:0]           n_r, n_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [VW-1:0]           pend_r, pend_nxt;
  logic                    out_valid_r;
  logic [VTX_W-1:0]        out_v_r;
  logic                    out_last_r;

  logic [VW+VTX_W-1:0]     a_ext, b_ext, o_ext;
  logic                    a_ok, b_ok;
  logic                    accept, out_free, emit, emit_last;

  logic                    adj_we;
  logic [VW-1:0]           adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_q, cur_row;

  logic                    stk_we;
  logic [VW-1:0]           stk_waddr, stk_raddr;
  logic [SW-1:0]           stk_wdata, stk_q;
  logic [DW-1:0]           depth_m1, depth_m2;

  logic                    find_hit;
  logic [VW-1:0]           find_idx;
  logic [IW-1:0]           find_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;

  assign a_ext = {{VW{1'b0}}, in_from_vertex};
  assign b_ext = {{VW{1'b0}}, in_to_vertex};
  assign a_ok  = a_ext < (VW+VTX_W)'(MAX_VERTICES);
  assign b_ok  = b_ext < (VW+VTX_W)'(MAX_VERTICES);
  assign o_ext = {{VTX_W{1'b0}}, pend_r};

  assign depth_m1  = depth_r - DW'(1);
  assign depth_m2  = depth_r - DW'(2);
  assign stk_raddr = depth_m2[VW-1:0];
  assign stk_waddr = depth_m1[VW-1:0];
  assign stk_wdata = {cur_v_r, find_next};
  assign find_next = {1'b0, find_idx} + IW'(1);

  assign cur_row = row_vld_r[cur_v_r] ? adj_q : '0;

  always_comb begin
    unique case (state_r)
      S_IDLE:  adj_raddr = a_ext[VW-1:0];
      S_E_WA:  adj_raddr = e_b_r;
      default: adj_raddr = cur_v_r;
    endcase
  end

  dfw_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_q)
  );

  dfw_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_VERTICES)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  dfw_find #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_find (
    .row      (cur_row),
    .visited  (visited_r),
    .from_idx (cur_i_r),
    .count    (vcount_r),
    .hit      (find_hit),
    .idx      (find_idx)
  );

  always_comb begin
    state_nxt   = state_r;
    row_vld_nxt = row_vld_r;
    e_a_nxt     = e_a_r;
    e_b_nxt     = e_b_r;
    cur_v_nxt   = cur_v_r;
    cur_i_nxt   = cur_i_r;
    depth_nxt   = depth_r;
    n_nxt       = n_r;
    visited_nxt = visited_r;
    pend_nxt    = pend_r;
    adj_we      = 1'b0;
    adj_waddr   = e_a_r;
    adj_wdata   = (row_vld_r[e_a_r] ? adj_q : '0) | (MAX_VERTICES'(1) << e_b_r);
    stk_we      = 1'b0;
    emit        = 1'b0;
    emit_last   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          e_a_nxt = a_ext[VW-1:0];
          e_b_nxt = b_ext[VW-1:0];
          case (in_op)
            OP_CLEAR: begin
              row_vld_nxt = '0;
              visited_nxt = '0;
              depth_nxt   = '0;
            end
            OP_EDGE: begin
              if (a_ok && b_ok) begin
                state_nxt = S_E_WA;
              end
            end
            OP_WALK: begin
              visited_nxt = '0;
              depth_nxt   = '0;
              if (a_ok) begin
                visited_nxt = MAX_VERTICES'(1) << a_ext[VW-1:0];
                cur_v_nxt   = a_ext[VW-1:0];
                cur_i_nxt   = '0;
                depth_nxt   = DW'(1);
                n_nxt       = NW'(1);
                pend_nxt    = a_ext[VW-1:0];
                state_nxt   = S_W_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_E_WA: begin
        adj_we               = 1'b1;
        row_vld_nxt[e_a_r]   = 1'b1;
        state_nxt            = (e_a_r == e_b_r) ? S_IDLE : S_E_WB;
      end
      S_E_WB: begin
        adj_we             = 1'b1;
        adj_waddr          = e_b_r;
        adj_wdata          = (row_vld_r[e_b_r] ? adj_q : '0) | (MAX_VERTICES'(1) << e_a_r);
        row_vld_nxt[e_b_r] = 1'b1;
        state_nxt          = S_IDLE;
      end
      S_W_RD: begin
        state_nxt = S_W_SRCH;
      end
      S_W_SRCH: begin
        if (find_hit) begin
          if (out_free) begin
            emit        = 1'b1;
            visited_nxt = visited_r | (MAX_VERTICES'(1) << find_idx);
            pend_nxt    = find_idx;
            n_nxt       = n_r + NW'(1);
            if (depth_r < DW'(MAX_VERTICES)) begin
              stk_we    = 1'b1;
              cur_v_nxt = find_idx;
              cur_i_nxt = '0;
              depth_nxt = depth_r + DW'(1);
            end else begin
              cur_i_nxt = find_next;
            end
            state_nxt = (n_r == NW'(RESULT_LIMIT - 1)) ? S_W_END : S_W_RD;
          end
        end else begin
          depth_nxt = depth_m1;
          state_nxt = (depth_r == DW'(1)) ? S_W_END : S_W_POP;
        end
      end
      S_W_POP: begin
        cur_v_nxt = stk_q[SW-1:IW];
        cur_i_nxt = stk_q[IW-1:0];
        state_nxt = S_W_RD;
      end
      S_W_END: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          depth_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      row_vld_r   <= '0;
      visited_r   <= '0;
      depth_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_vld_r <= row_vld_nxt;
      visited_r <= visited_nxt;
      depth_r   <= depth_nxt;
      n_r       <= n_nxt;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_vertex_count;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_a_r   <= e_a_nxt;
    e_b_r   <= e_b_nxt;
    cur_v_r <= cur_v_nxt;
    cur_i_r <= cur_i_nxt;
    pend_r  <= pend_nxt;
    if (emit) begin
      out_v_r    <= o_ext[VTX_W-1:0];
      out_last_r <= emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_visited_vertex = out_v_r;
  assign out_last           = out_last_r;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_VERTICES))
    else $error("walk stack depth beyond vertex limit");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(RESULT_LIMIT))
    else $error("walk result count beyond limit");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("last transfer did not end the walk");

  a_walk_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_RD || state_r == S_W_SRCH || state_r == S_W_POP ||
     state_r == S_W_END) |-> (visited_r != '0))
    else $error("walk running with empty visited set");
`endif

endmodule

FILE: hw/rtl/dfw_ram.sv
module dfw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = dfw_pkg::MAX_VERTICES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/dfw_find.sv
module dfw_find #(
  parameter int MAX_VERTICES = dfw_pkg::MAX_VERTICES_DEF
) (
  input  logic [MAX_VERTICES-1:0]           row,
  input  logic [MAX_VERTICES-1:0]           visited,
  input  logic [$clog2(MAX_VERTICES):0]     from_idx,
  input  logic [dfw_pkg::CNT_W-1:0]         count,
  output logic                              hit,
  output logic [$clog2(MAX_VERTICES)-1:0]   idx
);
  import dfw_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);

  logic [MAX_VERTICES-1:0] cand;
  logic [MAX_VERTICES-1:0] low;

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      cand[j] = row[j] & ~visited[j] & (j >= int'(from_idx)) & (j < int'(count));
    end
    low = cand & (~cand + MAX_VERTICES'(1));
    idx = '0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (low[j]) begin
        idx = idx | VW'(j);
      end
    end
    hit = |cand;
  end

endmodule

FILE: tb/sv/graph_depth_first_walk_core_tb.sv
`timescale 1ns / 100ps

module graph_depth_first_walk_core_tb;
  import dfw_pkg::*;

  localparam int NUM_VTX      = MAX_VERTICES_DEF;
  localparam int SETTLE_CYC   = 12;
  localparam int DRAIN_CYC    = 100;
  localparam int CYCLE_LIMIT  = 500000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             is_last;
  } visit_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_vertex_count;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_op;
  logic [VTX_W-1:0]  in_from_vertex;
  logic [VTX_W-1:0]  in_to_vertex;
  logic              out_valid;
  logic              out_ready;
  logic [VTX_W-1:0]  out_visited_vertex;
  logic              out_last;

  logic [NUM_VTX-1:0] adj_rows [NUM_VTX];
  logic [CNT_W-1:0]   vtx_count;
  visit_t             expected_visits [$];
  bit                 calm;
  int                 errors;
  int                 walk_count;
  int                 edge_count;
  int                 clear_count;
  int                 visits_checked;
  int                 count_writes;
  int                 cycle_count;

  graph_depth_first_walk_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_vertex_count   (cfg_vertex_count),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_from_vertex     (in_from_vertex),
    .in_to_vertex       (in_to_vertex),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_visited_vertex (out_visited_vertex),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("tb: failure");
    $finish;
  end

  // preorder walk with an explicit frame stack; appends the visits it emits
  task automatic predict_walk(input logic [VTX_W-1:0] start);
    int          stk_vtx [NUM_VTX];
    int          stk_next [NUM_VTX];
    int          depth;
    int          top;
    int          v;
    int          i;
    int          limit;
    int          n;
    logic [NUM_VTX-1:0] seen;
    limit = (vtx_count > NUM_VTX) ? NUM_VTX : int'(vtx_count);
    seen = '0;
    seen[start] = 1'b1;
    stk_vtx[0] = start;
    stk_next[0] = 0;
    depth = 1;
    expected_visits.push_back('{vertex: start, is_last: 1'b0});
    n = 1;
    while (depth > 0 && n < RESULT_LIMIT) begin
      top = depth - 1;
      v = stk_vtx[top];
      i = stk_next[top];
      while (i < limit && !(adj_rows[v][i] && !seen[i]))
        i++;
      if (i < limit) begin
        stk_next[top] = i + 1;
        seen[i] = 1'b1;
        if (depth < NUM_VTX) begin
          stk_vtx[depth] = i;
          stk_next[depth] = 0;
          depth++;
        end
        expected_visits.push_back('{vertex: VTX_W'(i), is_last: 1'b0});
        n++;
      end else begin
        depth--;
      end
    end
    expected_visits[expected_visits.size()-1].is_last = 1'b1;
  endtask

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VTX_W-1:0] a,
                          input logic [VTX_W-1:0] b);
    if (!calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_from_vertex <= a;
    in_to_vertex   <= b;
    do @(posedge clk); while (!in_ready);
    case (op)
      OP_CLEAR: begin
        foreach (adj_rows[r]) adj_rows[r] = '0;
        clear_count++;
      end
      OP_EDGE: begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
        edge_count++;
      end
      OP_WALK: begin
        predict_walk(a);
        walk_count++;
      end
      default: ;
    endcase
  endtask

  task automatic set_vertex_count(input logic [CNT_W-1:0] count);
    in_valid <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_vertex_count <= count;
    do @(posedge clk); while (!cfg_ready);
    vtx_count = count;
    count_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    // count is zero out of reset: a walk only emits its start
    send_cmd(OP_WALK, 4'd0, 4'd0);
    send_cmd(OP_WALK, 4'd15, 4'd15);
  endtask

  task automatic test_full_chain();
    set_vertex_count(5'd16);
    for (int k = 0; k < NUM_VTX - 1; k++)
      send_cmd(OP_EDGE, VTX_W'(k), VTX_W'(k + 1));
    send_cmd(OP_EDGE, 4'd3, 4'd3);
    send_cmd(OP_WALK, 4'd0, 4'd0);
    send_cmd(OP_WALK, 4'd8, 4'd0);
  endtask

  task automatic test_count_window();
    send_cmd(OP_UNUSED, 4'd15, 4'd15);
    set_vertex_count(5'd3);
    send_cmd(OP_WALK, 4'd15, 4'd5);
    send_cmd(OP_WALK, 4'd1, 4'd0);
    set_vertex_count(5'd31);
    send_cmd(OP_WALK, 4'd12, 4'd0);
    send_cmd(OP_CLEAR, 4'd0, 4'd0);
    send_cmd(OP_WALK, 4'd5, 4'd0);
  endtask

  task automatic test_random_graphs();
    int roll;
    logic [CNT_W-1:0] count;
    for (int phase = 0; phase < 11; phase++) begin
      case (phase)
        0:       count = 5'd16;
        1:       count = 5'd0;
        2:       count = 5'd31;
        3:       count = 5'd15;
        4:       count = 5'd1;
        default: count = CNT_W'($urandom_range(0, 31));
      endcase
      set_vertex_count(count);
      calm = (phase == 3 || phase == 4);
      if ($urandom_range(0, 99) < 80)
        send_cmd(OP_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
      for (int k = 0; k < 26; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 58)
          send_cmd(OP_EDGE, VTX_W'($urandom_range(0, 15)), VTX_W'($urandom_range(0, 15)));
        else if (roll < 92)
          send_cmd(OP_WALK, VTX_W'($urandom_range(0, 15)), VTX_W'($urandom));
        else if (roll < 97)
          send_cmd(OP_UNUSED, VTX_W'($urandom), VTX_W'($urandom));
        else
          send_cmd(OP_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    visit_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_visits.size() == 0) begin
          $error("unexpected transfer: visited_vertex %0d last %0b",
                 out_visited_vertex, out_last);
          errors++;
        end else begin
          want = expected_visits.pop_front();
          visits_checked++;
          if (out_visited_vertex !== want.vertex) begin
            $error("visited_vertex: expected %0d, actual %0d", want.vertex,
                   out_visited_vertex);
            errors++;
          end
          if (out_last !== want.is_last) begin
            $error("last: expected %0b, actual %0b", want.is_last, out_last);
            errors++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 35);
    end
  end

  initial begin
    errors = 0;
    walk_count = 0;
    edge_count = 0;
    clear_count = 0;
    visits_checked = 0;
    count_writes = 0;
    calm = 1'b0;
    vtx_count = '0;
    foreach (adj_rows[r]) adj_rows[r] = '0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_op            <= OP_CLEAR;
    in_from_vertex   <= '0;
    in_to_vertex     <= '0;
    cfg_valid        <= 1'b0;
    cfg_vertex_count <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_full_chain();
    test_count_window();
    test_random_graphs();

    in_valid <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (expected_visits.size() != 0) begin
      $error("%0d expected visits never arrived", expected_visits.size());
      errors++;
    end
    $display("walks %0d, edge adds %0d, clears %0d, vertex count writes %0d",
             walk_count, edge_count, clear_count, count_writes);
    $display("visit transfers checked %0d, mismatches %0d", visits_checked, errors);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: graph_depth_first_walk_core.f
hw/rtl/dfw_pkg.sv
hw/rtl/dfw_ram.sv
hw/rtl/dfw_find.sv
hw/rtl/graph_depth_first_walk_core.sv
tb/sv/graph_depth_first_walk_core_tb.sv
